FILE: design/hcer_pkg.sv
package hcer_pkg;

  localparam int STAMP_W     = 32;
  localparam int CODE_W      = 32;
  localparam int TAP_W       = 64;
  localparam int TIME_W      = 48;
  localparam int FRAC_W      = 16;
  localparam int N_BYTES     = 8;
  localparam int BYTE_CNT_W  = 4;
  localparam int SUM_W       = 7;

  localparam logic [FRAC_W-1:0] LIMIT_RESET = 16'd64880;

  typedef struct packed {
    logic [CODE_W-1:0]  coarse_stamp;
    logic [CODE_W-1:0]  delay_code_high;
    logic [CODE_W-1:0]  delay_code_low;
    logic [CODE_W-1:0]  calib_code_high;
    logic [CODE_W-1:0]  calib_code_low;
    logic               edge_falling;
  } hcer_in_t;

  typedef struct packed {
    logic [TIME_W-1:0]  refined_time;
    logic [FRAC_W-1:0]  cycle_fraction;
    logic [TIME_W-1:0]  high_time;
    logic               high_time_valid;
    logic [TIME_W-1:0]  low_time;
    logic               low_time_valid;
    logic [TIME_W-1:0]  cycle_period;
    logic               period_valid;
    logic               calib_zero;
  } hcer_out_t;

  typedef struct packed {
    logic capture;
    logic count;
    logic sum;
    logic load;
    logic step;
    logic fix;
    logic calc_time;
    logic write;
  } hcer_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } hcer_sts_t;

endpackage

FILE: design/hires_capture_edge_refiner.sv
// Channel  Ports                         Moves
// input    in_valid, in_stall, in_data   one captured edge item
// output   out_valid, out_stall, out_data one refined time item
// config   cfg_we, cfg_data              fraction limit, written any cycle
//
// QUO_W = clog2(DELAY_TAPS+1)+FRAC_BITS; the serial divider takes one quotient
// bit per cycle. New items are taken once the result is in the output register.
// An item goes through count, sum, load, divide, fix, time and write states.
// Synchronous active-low reset clears the edge history and loads limit 64880.
// A stalled result holds the block only when the next one is ready to write.
module hires_capture_edge_refiner #(
  parameter int FRAC_BITS  = 16,
  parameter int DELAY_TAPS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hcer_pkg::hcer_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hcer_pkg::hcer_out_t out_data,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data
);
  import hcer_pkg::*;

  hcer_cmd_t cmd;
  hcer_sts_t sts;

  hcer_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  hcer_datapath #(
    .FRAC_BITS  (FRAC_BITS),
    .DELAY_TAPS (DELAY_TAPS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: design/hcer_datapath.sv
module hcer_datapath #(
  parameter int FRAC_BITS  = 16,
  parameter int DELAY_TAPS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hcer_pkg::hcer_in_t  in_data,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  input  hcer_pkg::hcer_cmd_t cmd,
  output hcer_pkg::hcer_sts_t sts,
  output logic                out_valid,
  input  logic                out_stall,
  output hcer_pkg::hcer_out_t out_data
);
  import hcer_pkg::*;

  localparam int CNT_W  = $clog2(DELAY_TAPS + 1);
  localparam int QUO_W  = CNT_W + FRAC_BITS;
  localparam int STEP_W = $clog2(QUO_W + 1);
  localparam int SCL_W  = STAMP_W + FRAC_BITS;
  localparam int WIDE_W = (SCL_W > TIME_W) ? SCL_W : TIME_W;
  localparam int CMP_W  = (QUO_W > FRAC_W) ? QUO_W : FRAC_W;
  localparam logic [TAP_W-1:0] TAP_MASK = (DELAY_TAPS >= TAP_W) ? {TAP_W{1'b1}} :
                                          ((TAP_W'(1) << DELAY_TAPS) - TAP_W'(1));

  logic [STAMP_W-1:0]    stamp_r;
  logic [TAP_W-1:0]      dcode_r;
  logic [TAP_W-1:0]      ccode_r;
  logic                  falling_r;
  logic [BYTE_CNT_W-1:0] dbyte_r   [N_BYTES];
  logic [BYTE_CNT_W-1:0] cbyte_r   [N_BYTES];
  logic [BYTE_CNT_W-1:0] dbyte_nxt [N_BYTES];
  logic [BYTE_CNT_W-1:0] cbyte_nxt [N_BYTES];
  logic [SUM_W-1:0]      dsum;
  logic [SUM_W-1:0]      csum;
  logic [CNT_W-1:0]      dcnt_r;
  logic [CNT_W-1:0]      ccnt_r;
  logic [CNT_W-1:0]      dcnt_nxt;
  logic [CNT_W-1:0]      rem_r;
  logic [CNT_W-1:0]      rem_nxt;
  logic [QUO_W-1:0]      quo_r;
  logic [QUO_W-1:0]      quo_nxt;
  logic [STEP_W-1:0]     step_r;
  logic [CNT_W:0]        trial;
  logic                  trial_ge;
  logic                  czero;
  logic                  over_limit;
  logic [FRAC_W-1:0]     frac_r;
  logic [FRAC_W-1:0]     frac_nxt;
  logic                  czero_r;
  logic [WIDE_W-1:0]     scaled_w;
  logic [WIDE_W-1:0]     frac_w;
  logic [TIME_W-1:0]     time_r;
  logic [TIME_W-1:0]     time_nxt;
  logic [TIME_W-1:0]     last_rise_r;
  logic [TIME_W-1:0]     last_fall_r;
  logic                  rise_seen_r;
  logic                  fall_seen_r;
  logic [TIME_W-1:0]     rise_diff;
  logic [TIME_W-1:0]     fall_diff;
  logic [FRAC_W-1:0]     limit_r;
  logic                  out_valid_r;
  hcer_out_t             out_r;
  hcer_out_t             out_nxt;

  always_comb begin
    for (int b = 0; b < N_BYTES; b++) begin
      dbyte_nxt[b] = '0;
      cbyte_nxt[b] = '0;
      for (int k = 0; k < 8; k++) begin
        dbyte_nxt[b] = dbyte_nxt[b] + BYTE_CNT_W'(dcode_r[8*b+k]);
        cbyte_nxt[b] = cbyte_nxt[b] + BYTE_CNT_W'(ccode_r[8*b+k]);
      end
    end
  end

  always_comb begin
    dsum = '0;
    csum = '0;
    for (int b = 0; b < N_BYTES; b++) begin
      dsum = dsum + SUM_W'(dbyte_r[b]);
      csum = csum + SUM_W'(cbyte_r[b]);
    end
    dcnt_nxt = falling_r ? CNT_W'(DELAY_TAPS) - CNT_W'(dsum) : CNT_W'(dsum);
  end

  always_comb begin
    trial    = {rem_r, quo_r[QUO_W-1]};
    trial_ge = trial >= {1'b0, ccnt_r};
    rem_nxt  = CNT_W'(trial_ge ? trial - {1'b0, ccnt_r} : trial);
    quo_nxt  = {quo_r[QUO_W-2:0], trial_ge};
  end

  always_comb begin
    czero      = (ccnt_r == '0);
    over_limit = CMP_W'(quo_r) >= CMP_W'(limit_r);
    frac_nxt   = (czero || over_limit) ? '0 : FRAC_W'(quo_r);
  end

  always_comb begin
    scaled_w = WIDE_W'(stamp_r) << FRAC_BITS;
    frac_w   = WIDE_W'(frac_r);
    time_nxt = (frac_w > scaled_w) ? '0 : TIME_W'(scaled_w - frac_w);
  end

  always_comb begin
    rise_diff = time_r - last_rise_r;
    fall_diff = time_r - last_fall_r;
    out_nxt.refined_time    = time_r;
    out_nxt.cycle_fraction  = frac_r;
    out_nxt.high_time_valid = falling_r && rise_seen_r;
    out_nxt.high_time       = out_nxt.high_time_valid ? rise_diff : '0;
    out_nxt.low_time_valid  = !falling_r && fall_seen_r;
    out_nxt.low_time        = out_nxt.low_time_valid ? fall_diff : '0;
    out_nxt.period_valid    = !falling_r && rise_seen_r;
    out_nxt.cycle_period    = out_nxt.period_valid ? rise_diff : '0;
    out_nxt.calib_zero      = czero_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      stamp_r   <= in_data.coarse_stamp;
      dcode_r   <= {in_data.delay_code_high, in_data.delay_code_low} & TAP_MASK;
      ccode_r   <= {in_data.calib_code_high, in_data.calib_code_low} & TAP_MASK;
      falling_r <= in_data.edge_falling;
    end
    if (cmd.count) begin
      dbyte_r <= dbyte_nxt;
      cbyte_r <= cbyte_nxt;
    end
    if (cmd.sum) begin
      dcnt_r <= dcnt_nxt;
      ccnt_r <= CNT_W'(csum);
    end
    if (cmd.load) begin
      rem_r  <= '0;
      quo_r  <= {dcnt_r, FRAC_BITS'(0)};
      step_r <= STEP_W'(QUO_W);
    end else if (cmd.step) begin
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      step_r <= step_r - STEP_W'(1);
    end
    if (cmd.fix) begin
      frac_r  <= frac_nxt;
      czero_r <= czero;
    end
    if (cmd.calc_time) begin
      time_r <= time_nxt;
    end
    if (cmd.write) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_RESET;
      last_rise_r <= '0;
      last_fall_r <= '0;
      rise_seen_r <= 1'b0;
      fall_seen_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_data;
      end
      if (cmd.write) begin
        if (falling_r) begin
          last_fall_r <= time_r;
          fall_seen_r <= 1'b1;
        end else begin
          last_rise_r <= time_r;
          rise_seen_r <= 1'b1;
        end
      end
      if (cmd.write) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.div_last = (step_r == STEP_W'(1));
  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

`ifndef SYNTHESIS
  a_czero_frac: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.calib_zero |-> out_r.cycle_fraction == '0)
    else $error("fraction nonzero with empty calibration");
  a_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.high_time_valid |-> out_r.high_time == '0)
    else $error("high time nonzero without measurement");
  a_edge_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.high_time_valid && (out_r.period_valid || out_r.low_time_valid)))
    else $error("falling and rising measurements in one item");
`endif

endmodule

FILE: design/hcer_controller.sv
module hcer_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hcer_pkg::hcer_sts_t sts,
  output hcer_pkg::hcer_cmd_t cmd
);
  import hcer_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_COUNT = 8'b0000_0010,
    ST_SUM   = 8'b0000_0100,
    ST_LOAD  = 8'b0000_1000,
    ST_DIV   = 8'b0001_0000,
    ST_FIX   = 8'b0010_0000,
    ST_TIME  = 8'b0100_0000,
    ST_WRITE = 8'b1000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_COUNT;
      ST_COUNT: state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_DIV;
      ST_DIV:   if (sts.div_last) state_nxt = ST_FIX;
      ST_FIX:   state_nxt = ST_TIME;
      ST_TIME:  state_nxt = ST_WRITE;
      ST_WRITE: if (sts.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall      = (state_r != ST_IDLE);
  assign cmd.capture   = (state_r == ST_IDLE) && in_valid;
  assign cmd.count     = (state_r == ST_COUNT);
  assign cmd.sum       = (state_r == ST_SUM);
  assign cmd.load      = (state_r == ST_LOAD);
  assign cmd.step      = (state_r == ST_DIV);
  assign cmd.fix       = (state_r == ST_FIX);
  assign cmd.calc_time = (state_r == ST_TIME);
  assign cmd.write     = (state_r == ST_WRITE) && sts.out_free;

endmodule

FILE: verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hcer_pkg::*;

  localparam logic RISE = 1'b0;
  localparam logic FALL = 1'b1;
  localparam logic [TAP_W-1:0] ONES = '1;
  localparam int N_ROWS = 16;
  localparam int N_PHASES = 6;
  localparam int PHASE_ITEMS = 184;

  typedef struct {
    hcer_in_t  e;
    bit        typed;
    hcer_out_t want;
  } edge_row_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  hcer_in_t         in_data;
  logic             out_valid;
  logic             out_stall;
  hcer_out_t        out_data;
  logic             cfg_we;
  logic [FRAC_W-1:0] cfg_data;

  logic [FRAC_W-1:0] frac_limit = LIMIT_RESET;
  logic [TIME_W-1:0] last_rise = '0;
  logic [TIME_W-1:0] last_fall = '0;
  logic              rise_seen = 1'b0;
  logic              fall_seen = 1'b0;

  hcer_out_t         refined_due[$];
  hcer_out_t         due;
  edge_row_t         edge_table [N_ROWS];
  logic [FRAC_W-1:0] phase_limit [N_PHASES];
  logic [STAMP_W-1:0] stamp_next = '0;
  logic              pol_next = RISE;
  bit                calm = 1'b0;
  int                fail_count = 0;

  hires_capture_edge_refiner dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb failed");
    $finish;
  end

  function automatic int unsigned tap_count(logic [TAP_W-1:0] v);
    return $countones(v);
  endfunction

  function automatic logic [TAP_W-1:0] thermo(int unsigned n);
    if (n == 0) return '0;
    return ONES >> (TAP_W - n);
  endfunction

  function automatic hcer_out_t refine_edge(hcer_in_t e);
    hcer_out_t         r;
    int unsigned       dcnt;
    int unsigned       ccnt;
    logic [TIME_W-1:0] frac;
    logic [TIME_W-1:0] scaled;
    r = '0;
    frac = '0;
    dcnt = tap_count({e.delay_code_high, e.delay_code_low});
    ccnt = tap_count({e.calib_code_high, e.calib_code_low});
    if (e.edge_falling == FALL) dcnt = TAP_W - dcnt;
    r.calib_zero = (ccnt == 0);
    if (ccnt != 0) begin
      frac = (TIME_W'(dcnt) << FRAC_W) / TIME_W'(ccnt);
      if (frac >= TIME_W'(frac_limit)) frac = '0;
    end
    scaled = {e.coarse_stamp, {FRAC_W{1'b0}}};
    r.refined_time = (frac > scaled) ? '0 : scaled - frac;
    r.cycle_fraction = frac[FRAC_W-1:0];
    if (e.edge_falling == FALL) begin
      if (rise_seen) begin
        r.high_time = r.refined_time - last_rise;
        r.high_time_valid = 1'b1;
      end
      last_fall = r.refined_time;
      fall_seen = 1'b1;
    end else begin
      if (fall_seen) begin
        r.low_time = r.refined_time - last_fall;
        r.low_time_valid = 1'b1;
      end
      if (rise_seen) begin
        r.cycle_period = r.refined_time - last_rise;
        r.period_valid = 1'b1;
      end
      last_rise = r.refined_time;
      rise_seen = 1'b1;
    end
    return r;
  endfunction

  function automatic hcer_out_t res(logic [TIME_W-1:0] t, logic [FRAC_W-1:0] f,
                                    logic [TIME_W-1:0] hi, logic hv,
                                    logic [TIME_W-1:0] lo, logic lv,
                                    logic [TIME_W-1:0] per, logic pv, logic cz);
    hcer_out_t r;
    r.refined_time    = t;
    r.cycle_fraction  = f;
    r.high_time       = hi;
    r.high_time_valid = hv;
    r.low_time        = lo;
    r.low_time_valid  = lv;
    r.cycle_period    = per;
    r.period_valid    = pv;
    r.calib_zero      = cz;
    return r;
  endfunction

  function automatic edge_row_t row(logic [STAMP_W-1:0] st, logic [TAP_W-1:0] d,
                                    logic [TAP_W-1:0] c, logic f, bit typed,
                                    hcer_out_t want);
    edge_row_t r;
    r.e.coarse_stamp    = st;
    r.e.delay_code_high = d[63:32];
    r.e.delay_code_low  = d[31:0];
    r.e.calib_code_high = c[63:32];
    r.e.calib_code_low  = c[31:0];
    r.e.edge_falling    = f;
    r.typed             = typed;
    r.want              = want;
    return r;
  endfunction

  function automatic hcer_in_t rand_edge();
    hcer_in_t         e;
    int unsigned      pick;
    int unsigned      ccnt;
    logic [TAP_W-1:0] d;
    logic [TAP_W-1:0] c;
    pick = $urandom_range(99);
    if (pick < 70) begin
      stamp_next += $urandom_range(1, 5000);
      if ($urandom_range(9) != 0) pol_next = ~pol_next;
      ccnt = $urandom_range(40, 64);
      c = thermo(ccnt);
      d = thermo($urandom_range(0, ccnt));
      if ($urandom_range(7) == 0) d[6'($urandom_range(63))] ^= 1'b1;
      e.coarse_stamp = stamp_next;
      e.edge_falling = pol_next;
    end else if (pick < 85) begin
      d = {$urandom, $urandom};
      c = {$urandom, $urandom};
      e.coarse_stamp = $urandom;
      e.edge_falling = 1'($urandom_range(1));
    end else if (pick < 95) begin
      c = thermo($urandom_range(0, 4));
      d = thermo($urandom_range(0, 4));
      e.coarse_stamp = $urandom_range(3);
      e.edge_falling = 1'($urandom_range(1));
    end else begin
      c = ONES;
      d = thermo($urandom_range(0, 64));
      e.coarse_stamp = 32'hFFFF_FFFF - $urandom_range(100);
      e.edge_falling = 1'($urandom_range(1));
    end
    e.delay_code_high = d[63:32];
    e.delay_code_low  = d[31:0];
    e.calib_code_high = c[63:32];
    e.calib_code_low  = c[31:0];
    return e;
  endfunction

  function automatic void check_field(string name, logic [TIME_W-1:0] want,
                                      logic [TIME_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic send_edge(hcer_in_t e, bit typed, hcer_out_t want);
    hcer_out_t predicted;
    if (!calm && $urandom_range(3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = refine_edge(e);
    refined_due.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (refined_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_limit(logic [FRAC_W-1:0] v);
    cfg_data = v;
    cfg_we   = 1'b1;
    @(negedge clk);
    cfg_we     = 1'b0;
    frac_limit = v;
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      if (calm) begin
        out_stall = 1'b0;
        @(negedge clk);
      end else begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 11)) begin
          @(negedge clk);
          if (calm) break;
        end
        out_stall = 1'b0;
        repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 80 : 25)) begin
          @(negedge clk);
          if (calm) break;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (refined_due.size() == 0) begin
        $error("result item with no expected item waiting");
        fail_count++;
      end else begin
        due = refined_due.pop_front();
        check_field("refined_time", due.refined_time, out_data.refined_time);
        check_field("cycle_fraction", TIME_W'(due.cycle_fraction),
                    TIME_W'(out_data.cycle_fraction));
        check_field("high_time", due.high_time, out_data.high_time);
        check_field("high_time_valid", TIME_W'(due.high_time_valid),
                    TIME_W'(out_data.high_time_valid));
        check_field("low_time", due.low_time, out_data.low_time);
        check_field("low_time_valid", TIME_W'(due.low_time_valid),
                    TIME_W'(out_data.low_time_valid));
        check_field("cycle_period", due.cycle_period, out_data.cycle_period);
        check_field("period_valid", TIME_W'(due.period_valid),
                    TIME_W'(out_data.period_valid));
        check_field("calib_zero", TIME_W'(due.calib_zero),
                    TIME_W'(out_data.calib_zero));
      end
    end
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    cfg_we   = 1'b0;
    cfg_data = LIMIT_RESET;

    edge_table = '{
      row(0, 0, 0, RISE, 1, res(0, 0, 0, 0, 0, 0, 0, 0, 1)),
      row(1, ONES, ONES, FALL, 1, res(48'h1_0000, 0, 48'h1_0000, 1, 0, 0, 0, 0, 0)),
      row(2, ONES, ONES, RISE, 1,
          res(48'h2_0000, 0, 0, 0, 48'h1_0000, 1, 48'h2_0000, 1, 0)),
      row(32'hFFFF_FFFF, 0, ONES, RISE, 1,
          res(48'hFFFF_FFFF_0000, 0, 0, 0, 48'hFFFF_FFFE_0000, 1,
              48'hFFFF_FFFD_0000, 1, 0)),
      row(0, 0, thermo(1), FALL, 1, res(0, 0, 48'h1_0000, 1, 0, 0, 0, 0, 0)),
      row(0, thermo(1), thermo(2), RISE, 1,
          res(0, 16'h8000, 0, 0, 0, 1, 48'h1_0000, 1, 0)),
      row(5, thermo(1), thermo(3), RISE, 0, '0),
      row(100, thermo(63), ONES, RISE, 0, '0),
      row(101, thermo(1), ONES, FALL, 0, '0),
      row(200, ONES, 0, FALL, 0, '0),
      row(300, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, RISE, 0, '0),
      row(32'h8000_0000, 64'h0000_0001_8000_0000, 64'hFFFF_0000_0000_FFFF, FALL, 0, '0),
      row(32'h8000_0001, thermo(20), thermo(40), RISE, 0, '0),
      row(1, thermo(63), thermo(64), RISE, 0, '0),
      row(0, thermo(50), thermo(60), FALL, 0, '0),
      row(32'hFFFF_FFFE, thermo(10), thermo(33), FALL, 0, '0)
    };
    phase_limit = '{16'hFFFF, 16'h0000, 16'h0001, 16'($urandom), 16'h8000, LIMIT_RESET};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (edge_table[i]) send_edge(edge_table[i].e, edge_table[i].typed, edge_table[i].want);

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      write_limit(phase_limit[p]);
      if (p == N_PHASES - 1) calm = 1'b1;
      repeat (PHASE_ITEMS) send_edge(rand_edge(), 1'b0, '0);
    end

    drain();
    repeat (60) @(negedge clk);
    if (fail_count == 0 && refined_due.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
